### design/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the nearest point search
// Field widths, command codes, back end states and the queue word layout.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int COORD_W        = 14;
  localparam int SLOT_W         = 8;
  localparam int COUNT_W        = 9;
  localparam int INDEX_W        = 8;
  localparam int DIST_W         = 29;
  localparam int SQ_W           = 28;
  localparam int MAX_POINTS_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    cmd_t                       op;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } entry_t;

endpackage

### design/nps_if.sv
// ----------------------------------------------------------------------------
// nps_if: channel interfaces of the nearest point search
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nps_req_if;
  import nps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  modport source (output valid, cmd, slot, coord_x, coord_y, input ready);
  modport sink   (input valid, cmd, slot, coord_x, coord_y, output ready);
endinterface

interface nps_rsp_if;
  import nps_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] nearest_index;
  logic [DIST_W-1:0]  distance_squared;
  modport source (output valid, nearest_index, distance_squared, input ready);
  modport sink   (input valid, nearest_index, distance_squared, output ready);
endinterface

interface nps_cfg_if;
  import nps_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] point_count;
  modport source (output valid, point_count, input ready);
  modport sink   (input valid, point_count, output ready);
endinterface

### design/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nps_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/nps_fifo.sv
// ----------------------------------------------------------------------------
// nps_fifo: short queue between front and back end
// Register based FIFO; depth is a power of two.
// ----------------------------------------------------------------------------
module nps_fifo #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

### design/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front: request intake
// Accept request words, classify load or query, drop loads beyond the table.
// ----------------------------------------------------------------------------
module nps_front #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  nps_req_if.sink         req,
  input  logic            full,
  output logic            push,
  output nps_pkg::entry_t entry
);
  import nps_pkg::*;

  logic in_table;
  logic drop;

  assign in_table = (int'(req.slot) < MAX_POINTS);
  assign drop     = (cmd_t'(req.cmd) == CMD_LOAD) && !in_table;

  assign req.ready = !full;
  assign push      = req.valid && !full && !drop;

  assign entry.op   = cmd_t'(req.cmd);
  assign entry.slot = req.slot;
  assign entry.x    = req.coord_x;
  assign entry.y    = req.coord_y;

endmodule

### design/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back: table update and scan engine
// Write loads into the point RAM; scan it for queries, one point a cycle.
// ----------------------------------------------------------------------------
module nps_back #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  nps_pkg::entry_t                q_entry,
  output logic                           q_pop,
  input  logic [nps_pkg::COUNT_W-1:0]    point_count,
  output logic                           ram_we,
  output logic [$clog2(MAX_POINTS)-1:0]  ram_waddr,
  output logic [2*nps_pkg::COORD_W-1:0]  ram_wdata,
  output logic [$clog2(MAX_POINTS)-1:0]  ram_raddr,
  input  logic [2*nps_pkg::COORD_W-1:0]  ram_rdata,
  nps_rsp_if.source                      rsp
);
  import nps_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int MW = $clog2(MAX_POINTS + 1);
  localparam int LW = (COUNT_W > MW) ? COUNT_W : MW;

  state_t state, state_next;

  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             last_idx;
  logic [AW-1:0]             last_idx_next;
  logic [LW-1:0]             cnt_ext;

  logic                      s1_valid;
  logic                      s1_last;
  logic [AW-1:0]             s1_idx;
  logic                      s2_valid;
  logic                      s2_last;
  logic [AW-1:0]             s2_idx;
  logic [SQ_W-1:0]           sq_x;
  logic [SQ_W-1:0]           sq_y;

  logic [DIST_W-1:0]         best_d;
  logic [AW-1:0]             best_i;
  logic [DIST_W-1:0]         best_d_next;
  logic [AW-1:0]             best_i_next;
  logic [DIST_W-1:0]         sum;

  logic                      out_valid;
  logic [INDEX_W-1:0]        out_index;
  logic [DIST_W-1:0]         out_dist;

  logic                      issue;
  logic                      issue_last;
  logic                      start;

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W-1:0]        mag_x;
  logic [COORD_W-1:0]        mag_y;

  // clamp the count to 1 .. MAX_POINTS, keep the last index
  always_comb begin
    cnt_ext = LW'(point_count);
    if (cnt_ext == '0) begin
      last_idx_next = '0;
    end else if (cnt_ext > LW'(MAX_POINTS)) begin
      last_idx_next = AW'(MAX_POINTS - 1);
    end else begin
      last_idx_next = AW'(cnt_ext - LW'(1));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_valid && s2_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    start      = 1'b0;
    issue      = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_entry.op == CMD_LOAD) begin
            q_pop  = 1'b1;
            ram_we = 1'b1;
          end else if (!out_valid) begin
            q_pop = 1'b1;
            start = 1'b1;
          end
        end
      end
      ST_ISSUE: issue = 1'b1;
      ST_DRAIN: ;
      default: ;
    endcase
  end

  assign issue_last = issue && (idx == last_idx);
  assign ram_waddr  = AW'(q_entry.slot);
  assign ram_wdata  = {q_entry.x, q_entry.y};
  assign ram_raddr  = idx;

  // distance squares from the RAM word
  assign px    = ram_rdata[2*COORD_W-1:COORD_W];
  assign py    = ram_rdata[COORD_W-1:0];
  assign dx    = {qx[COORD_W-1], qx} - {px[COORD_W-1], px};
  assign dy    = {qy[COORD_W-1], qy} - {py[COORD_W-1], py};
  assign mag_x = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
  assign mag_y = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);

  // keep the running minimum, lowest index on a tie
  always_comb begin
    sum         = DIST_W'(sq_x) + DIST_W'(sq_y);
    best_d_next = best_d;
    best_i_next = best_i;
    if ((s2_idx == '0) || (sum < best_d)) begin
      best_d_next = sum;
      best_i_next = s2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qx       <= q_entry.x;
      qy       <= q_entry.y;
      last_idx <= last_idx_next;
    end
    s1_last <= issue_last;
    s1_idx  <= idx;
    s2_last <= s1_last;
    s2_idx  <= s1_idx;
    sq_x    <= mag_x * mag_x;
    sq_y    <= mag_y * mag_y;
    if (s2_valid) begin
      best_d <= best_d_next;
      best_i <= best_i_next;
    end
    if (s2_valid && s2_last) begin
      out_index <= INDEX_W'(best_i_next);
      out_dist  <= best_d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (start) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + AW'(1);
      end
      if (s2_valid && s2_last) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.nearest_index    = out_index;
  assign rsp.distance_squared = out_dist;

endmodule

### design/nearest_point_search.sv
// ----------------------------------------------------------------------------
// nearest_point_search: brute force 2-D nearest point search
// Keeps a table of Q6.8 reference points and answers nearest point queries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per item: cmd selects load (store coord_x/coord_y
//   into slot) or query (find the nearest stored point). rsp returns one
//   word per query: nearest_index and distance_squared. Loads return nothing.
//   cfg writes point_count, the number of slots a query scans; write it only
//   while the block is idle. Slots scanned by a query must have been loaded.
//   A two entry queue parts intake from the scan engine, so requests keep
//   flowing while the engine is busy or a response waits.
//   A load is written to the point RAM straight from the idle state. A query
//   occupies the engine for one RAM read a cycle over the scanned slots, then
//   two pipeline stages (square, then add and compare); the point RAM read
//   port sets the rate.
//   Reset empties the queue, drops any pending response and sets
//   point_count to 2; table contents stay undefined until loaded.
//   While rsp stalls, loads still proceed; the next query waits in the queue.
// ----------------------------------------------------------------------------
module nearest_point_search #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  nps_req_if.sink   req,
  nps_rsp_if.source rsp,
  nps_cfg_if.sink   cfg
);
  import nps_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int EW = $bits(entry_t);

  logic [COUNT_W-1:0]   point_count;
  logic                 push;
  entry_t               push_entry;
  logic                 full;
  logic                 pop;
  logic                 not_empty;
  logic [EW-1:0]        pop_data;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*COORD_W-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [2*COORD_W-1:0] ram_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_RESET;
    end else if (cfg.valid) begin
      point_count <= cfg.point_count;
    end
  end

  nps_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .req   (req),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  nps_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  nps_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nps_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (not_empty),
    .q_entry     (entry_t'(pop_data)),
    .q_pop       (pop),
    .point_count (point_count),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .rsp         (rsp)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the nearest point search
// Loads reference points and runs nearest point queries through the request
// channel. A directed table covers coordinate extremes, distance ties, the
// largest distance and the scan limit. Random phases then follow across
// point_count settings from zero to all ones. Every response word is checked
// against the answer in the directed table or a predictor of the point table.
// Random gaps and response stalls alternate with phases that run at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import nps_pkg::*;

  localparam int SLOTS       = MAX_POINTS_DEF;
  localparam int SETTLE      = 16;
  localparam int CYCLE_CAP   = 1000000;
  localparam int N_DIRECTED  = 22;
  localparam int N_PHASES    = 9;
  localparam int PHASE_WORDS = 30;
  localparam int MIN_QUERIES = 8;

  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  dist_sq;
  } answer_t;

  typedef struct packed {
    cmd_t                      op;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      typed;
    answer_t                   answer;
  } dir_row_t;

  logic clk;
  logic rst;
  bit   steady;
  int   stall_left;

  logic signed [COORD_W-1:0] pt_x [SLOTS];
  logic signed [COORD_W-1:0] pt_y [SLOTS];
  bit                        loaded [SLOTS];
  logic [COUNT_W-1:0]        scan_count;
  answer_t                   nearest_q [$];
  answer_t                   head_answer;
  dir_row_t                  directed_rows [N_DIRECTED];

  int errors    = 0;
  int n_loads   = 0;
  int n_queries = 0;
  int n_ties    = 0;
  int n_cfg     = 0;
  int n_results = 0;
  int cycles    = 0;

  nps_req_if req_ch ();
  nps_rsp_if rsp_ch ();
  nps_cfg_if cfg_ch ();

  nearest_point_search dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int scan_span();
    if (scan_count == 0) return 1;
    if (scan_count > SLOTS) return SLOTS;
    return int'(scan_count);
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < SLOTS && loaded[n]) n++;
    return n;
  endfunction

  function automatic answer_t find_nearest(input logic signed [COORD_W-1:0] qx,
                                           input logic signed [COORD_W-1:0] qy);
    int      dx;
    int      dy;
    int      d;
    int      best_d;
    int      best_i;
    bit      tie;
    answer_t a;
    best_d = 0;
    best_i = 0;
    tie = 1'b0;
    for (int i = 0; i < scan_span(); i++) begin
      dx = int'(qx) - int'(pt_x[i]);
      dy = int'(qy) - int'(pt_y[i]);
      d = dx * dx + dy * dy;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best_i = i;
        tie = 1'b0;
      end else if (d == best_d) begin
        tie = 1'b1;
      end
    end
    if (tie) n_ties++;
    a.index   = INDEX_W'(best_i);
    a.dist_sq = DIST_W'(best_d);
    return a;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    if (r < 65) return COORD_W'(int'($urandom_range(0, 8)) - 4);
    if (r < 80) return $urandom_range(0, 1) ? C_MAX : C_MIN;
    return COORD_W'(int'($urandom_range(0, 600)) - 300);
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_word(input cmd_t op, input logic [SLOT_W-1:0] slot,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic typed, input answer_t answer);
    int gap;
    req_ch.valid   = 1'b1;
    req_ch.cmd     = op;
    req_ch.slot    = slot;
    req_ch.coord_x = x;
    req_ch.coord_y = y;
    do @(posedge clk); while (!req_ch.ready);
    if (op == CMD_LOAD) begin
      pt_x[slot] = x;
      pt_y[slot] = y;
      loaded[slot] = 1'b1;
      n_loads++;
    end else begin
      nearest_q.push_back(typed ? answer : find_nearest(x, y));
      n_queries++;
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_ch.valid       = 1'b1;
    cfg_ch.point_count = value;
    do @(posedge clk); while (!cfg_ch.ready);
    scan_count = value;
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    req_ch.valid = 1'b0;
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // fill the scanned range first so no query reads an unloaded slot
  task automatic random_item(inout int queries_done);
    int                pre;
    logic [SLOT_W-1:0] slot;
    pre = loaded_prefix();
    if (pre < scan_span() || $urandom_range(0, 99) >= 55) begin
      if (pre < SLOTS && (pre < scan_span() || $urandom_range(0, 99) < 60))
        slot = SLOT_W'(pre);
      else
        slot = SLOT_W'($urandom_range(0, SLOTS - 1));
      send_word(CMD_LOAD, slot, pick_coord(), pick_coord(), 1'b0, '0);
    end else begin
      send_word(CMD_QUERY, SLOT_W'($urandom_range(0, SLOTS - 1)), pick_coord(),
                pick_coord(), 1'b0, '0);
      queries_done++;
    end
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (nearest_q.size() == 0) begin
        errors++;
        $display("%0t: response with nothing outstanding, index %0d distance %0d",
                 $time, rsp_ch.nearest_index, rsp_ch.distance_squared);
      end else begin
        head_answer = nearest_q.pop_front();
        if (rsp_ch.nearest_index !== head_answer.index) begin
          errors++;
          $display("%0t: nearest_index expected %0d, actual %0d",
                   $time, head_answer.index, rsp_ch.nearest_index);
        end
        if (rsp_ch.distance_squared !== head_answer.dist_sq) begin
          errors++;
          $display("%0t: distance_squared expected %0d, actual %0d",
                   $time, head_answer.dist_sq, rsp_ch.distance_squared);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycles, nearest_q.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int                 words;
    int                 queries_done;
    logic [COUNT_W-1:0] plan [N_PHASES];

    rst                = 1'b1;
    steady             = 1'b0;
    scan_count         = COUNT_RESET;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CMD_LOAD;
    req_ch.slot        = '0;
    req_ch.coord_x     = '0;
    req_ch.coord_y     = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.point_count = '0;

    directed_rows = '{
      '{CMD_LOAD,  8'd0,   14'sd0,    14'sd0,    1'b0, '0},
      '{CMD_LOAD,  8'd1,   14'sd100,  14'sd0,    1'b0, '0},
      '{CMD_QUERY, 8'd0,   14'sd0,    14'sd0,    1'b1, '{8'd0, 29'd0}},
      '{CMD_QUERY, 8'd255, 14'sd100,  14'sd0,    1'b1, '{8'd1, 29'd0}},
      '{CMD_QUERY, 8'd0,   14'sd50,   14'sd0,    1'b1, '{8'd0, 29'd2500}},
      '{CMD_QUERY, 8'd0,   C_MIN,     C_MIN,     1'b1, '{8'd0, 29'd134217728}},
      '{CMD_LOAD,  8'd1,   C_MIN,     C_MIN,     1'b0, '0},
      '{CMD_LOAD,  8'd0,   C_MAX,     C_MAX,     1'b0, '0},
      '{CMD_QUERY, 8'd0,   C_MAX,     C_MIN,     1'b1, '{8'd0, 29'd268402689}},
      '{CMD_QUERY, 8'd0,   C_MIN,     C_MAX,     1'b1, '{8'd0, 29'd268402689}},
      '{CMD_QUERY, 8'd0,   C_MAX,     C_MAX,     1'b1, '{8'd0, 29'd0}},
      '{CMD_QUERY, 8'd0,   C_MIN,     C_MIN,     1'b1, '{8'd1, 29'd0}},
      '{CMD_LOAD,  8'd0,   C_MIN,     C_MIN,     1'b0, '0},
      '{CMD_QUERY, 8'd0,   C_MAX,     C_MAX,     1'b1, '{8'd0, 29'd536805378}},
      '{CMD_LOAD,  8'd2,   -14'sd1,   -14'sd1,   1'b0, '0},
      '{CMD_LOAD,  8'd255, 14'sd1,    14'sd1,    1'b0, '0},
      '{CMD_QUERY, 8'd0,   -14'sd1,   -14'sd1,   1'b1, '{8'd0, 29'd134184962}},
      '{CMD_QUERY, 8'd0,   14'sd1234, -14'sd567, 1'b0, '0},
      '{CMD_QUERY, 8'd0,   14'sh1555, 14'sh2AAA, 1'b0, '0},
      '{CMD_LOAD,  8'd1,   14'sd3,    14'sd4,    1'b0, '0},
      '{CMD_QUERY, 8'd0,   14'sd0,    14'sd0,    1'b1, '{8'd1, 29'd25}},
      '{CMD_LOAD,  8'd128, 14'sh2AAA, 14'sh1555, 1'b0, '0}
    };

    plan = '{9'd0, 9'd1, 9'd2, 9'd0, 9'd0, 9'd511, 9'd256, 9'd0, 9'd255};
    plan[3] = COUNT_W'($urandom_range(3, 16));
    plan[4] = COUNT_W'($urandom_range(17, 64));
    plan[7] = COUNT_W'($urandom_range(100, 254));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_word(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].x,
                directed_rows[i].y, directed_rows[i].typed, directed_rows[i].answer);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      steady = (p == 2 || p == 6);
      write_count(plan[p]);
      words = 0;
      queries_done = 0;
      while (words < PHASE_WORDS || queries_done < MIN_QUERIES) begin
        random_item(queries_done);
        words++;
      end
      settle();
    end

    $display("covered %0d loads and %0d queries across %0d point_count writes",
             n_loads, n_queries, n_cfg);
    $display("%0d responses checked, %0d random queries resolved a distance tie",
             n_results, n_ties);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
